// File: hw/rtl/ubdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubdc_pkg - shared types and constants of the uart baud divisor calculator
// item structs, status codes, divider geometry and the slot pattern table
// ----------------------------------------------------------------------------
package ubdc_pkg;

  // field widths
  localparam int RateW   = 32;
  localparam int BaudW   = 24;
  localparam int DataW   = 4;
  localparam int ParW    = 2;
  localparam int StopW   = 2;
  localparam int StatW   = 3;
  localparam int DivW    = 28;
  localparam int SlotW   = 16;
  localparam int LcW     = 6;
  localparam int SlotIdxW = RateW - DivW;   // low quotient bits pick the slot

  // divider geometry: quotient of rate / baud, a few bits per stage
  localparam int RemW         = BaudW;
  localparam int AccW         = RemW + RateW;
  localparam int BitsPerStage = 2;
  localparam int Stages       = RateW / BitsPerStage;
  localparam int Latency      = Stages + 2;

  // argument limits and codes
  localparam logic [DataW-1:0] DataBitsMin = 4'd5;
  localparam logic [DataW-1:0] DataBitsMax = 4'd8;
  localparam logic [ParW-1:0]  ParNone     = 2'd0;
  localparam logic [ParW-1:0]  ParOdd      = 2'd1;
  localparam logic [ParW-1:0]  ParEven     = 2'd2;
  localparam logic [StopW-1:0] StopOne     = 2'd1;
  localparam logic [StopW-1:0] StopTwo     = 2'd2;
  localparam logic [2:0]       PcodeNone   = 3'd0;
  localparam logic [2:0]       PcodeOdd    = 3'd4;
  localparam logic [2:0]       PcodeEven   = 3'd5;

  typedef enum logic [StatW-1:0] {
    StOk        = 3'd0,
    StBadBaud   = 3'd1,
    StBadData   = 3'd2,
    StBadPar    = 3'd3,
    StBadStop   = 3'd4,
    StUnderflow = 3'd5
  } status_t;

  typedef struct packed {
    logic [BaudW-1:0] baud_rate;
    logic [DataW-1:0] data_bits;
    logic [ParW-1:0]  parity_mode;
    logic [StopW-1:0] stop_bits;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [DivW-1:0]  divisor;
    logic [SlotW-1:0] slot_code;
    logic [LcW-1:0]   line_control;
  } out_item_t;

  // fractional slot patterns, indexed by the slot number 0..15
  localparam logic [SlotW-1:0] SlotTable [2**SlotIdxW] = '{
    16'h0000, 16'h0080, 16'h0808, 16'h0888,
    16'h2222, 16'h4924, 16'h4a52, 16'h54aa,
    16'h5555, 16'hd555, 16'hd5d5, 16'hddd5,
    16'hdddd, 16'hdfdd, 16'hdfdf, 16'hffdf
  };

endpackage
`default_nettype wire

// File: hw/rtl/uart_baud_divisor_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc - uart baud divisor and line control calculator
// checks a line setting request and yields status, integer divisor,
// fractional slot pattern and the packed line control word
// ----------------------------------------------------------------------------
//
//  channel | ports                      | handshake
//  --------+----------------------------+------------------------------------
//  input   | start, busy, in_item       | item taken when start & !busy
//  result  | out_strobe, out_item       | one cycle per item, no back-pressure
//  config  | cfg_wr_en, cfg_wr_data     | clock_rate written when cfg_wr_en
//
//  each item passes the entry register, the divider stage registers and the result register
//  a new item may enter every cycle, set by the 16-stage divider pipeline
//  (two quotient bits per stage, one 25-bit compare and subtract per bit)
//  busy is always low: the pipeline never has to stop
//  rst_n synchronously clears the valid bits and clock_rate, payload is not reset
//  the receiver cannot stall, so results leave the moment they are ready
//
module uart_baud_divisor_calc (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire ubdc_pkg::in_item_t          in_item,
  // result channel
  output logic                             out_strobe,
  output ubdc_pkg::out_item_t              out_item,
  // configuration
  input  wire logic                        cfg_wr_en,
  input  wire logic [ubdc_pkg::RateW-1:0]  cfg_wr_data
);

  // state carried down the divider pipeline with each item
  typedef struct packed {
    ubdc_pkg::status_t               status;  // argument check result
    logic [ubdc_pkg::BaudW-1:0]      baud;    // divisor of the long division
    logic [ubdc_pkg::LcW-1:0]        lc;      // packed line control word
    logic [ubdc_pkg::AccW-1:0]       acc;     // {partial remainder, dividend/quotient}
  } stage_t;

  logic [ubdc_pkg::RateW-1:0] clock_rate_r;
  logic                       vld_r   [ubdc_pkg::Stages+1];
  stage_t                     stg_r   [ubdc_pkg::Stages+1];
  stage_t                     stg_nxt [ubdc_pkg::Stages+1];
  logic                       accept;
  logic                       out_strobe_r;
  ubdc_pkg::out_item_t        out_item_r;
  ubdc_pkg::out_item_t        out_item_nxt;

  // one restoring division step: shift in the next dividend bit, try subtract
  function automatic logic [ubdc_pkg::AccW-1:0] div_step(
    input logic [ubdc_pkg::AccW-1:0]  acc,
    input logic [ubdc_pkg::BaudW-1:0] d
  );
    logic [ubdc_pkg::RemW:0] t;
    logic [ubdc_pkg::RemW:0] diff;
    logic                    ge;
    t    = acc[ubdc_pkg::AccW-1 -: ubdc_pkg::RemW+1];
    diff = t - {1'b0, d};
    ge   = (t >= {1'b0, d});
    return {(ge ? diff[ubdc_pkg::RemW-1:0] : t[ubdc_pkg::RemW-1:0]),
            acc[ubdc_pkg::RateW-2:0], ge};
  endfunction

  // pipeline never back-pressures
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // configuration register: write only while no item is in flight, the block does not check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_rate_r <= '0;
    end else if (cfg_wr_en) begin
      clock_rate_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // entry stage: argument checks in priority order and line control packing
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [ubdc_pkg::DataW-1:0] dsub;
    logic [2:0]                 pcode;
    dsub  = in_item.data_bits - ubdc_pkg::DataBitsMin;
    pcode = ubdc_pkg::PcodeNone;
    if (in_item.parity_mode == ubdc_pkg::ParOdd) begin
      pcode = ubdc_pkg::PcodeOdd;
    end else if (in_item.parity_mode == ubdc_pkg::ParEven) begin
      pcode = ubdc_pkg::PcodeEven;
    end

    priority if (in_item.baud_rate == '0) begin
      stg_nxt[0].status = ubdc_pkg::StBadBaud;
    end else if (in_item.data_bits < ubdc_pkg::DataBitsMin ||
                 in_item.data_bits > ubdc_pkg::DataBitsMax) begin
      stg_nxt[0].status = ubdc_pkg::StBadData;
    end else if (in_item.parity_mode != ubdc_pkg::ParNone &&
                 in_item.parity_mode != ubdc_pkg::ParOdd &&
                 in_item.parity_mode != ubdc_pkg::ParEven) begin
      stg_nxt[0].status = ubdc_pkg::StBadPar;
    end else if (in_item.stop_bits != ubdc_pkg::StopOne &&
                 in_item.stop_bits != ubdc_pkg::StopTwo) begin
      stg_nxt[0].status = ubdc_pkg::StBadStop;
    end else begin
      stg_nxt[0].status = ubdc_pkg::StOk;
    end

    stg_nxt[0].baud = in_item.baud_rate;
    stg_nxt[0].lc   = {pcode, (in_item.stop_bits == ubdc_pkg::StopTwo), dsub[1:0]};
    // remainder starts at zero, the source clock rate is the dividend
    stg_nxt[0].acc  = {{ubdc_pkg::RemW{1'b0}}, clock_rate_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stg_r[0] <= stg_nxt[0];
  end

  // ---------------------------------------------------------------------------
  // divider stages: rate / baud, two quotient bits per stage
  // floor(rate / 16baud) is the quotient without its low four bits and
  // (rate mod 16baud) / baud is exactly those low four bits
  // ---------------------------------------------------------------------------
  for (genvar k = 1; k <= ubdc_pkg::Stages; k++) begin : g_div
    always_comb begin
      stg_nxt[k] = stg_r[k-1];
      for (int b = 0; b < ubdc_pkg::BitsPerStage; b++) begin
        stg_nxt[k].acc = div_step(stg_nxt[k].acc, stg_r[k-1].baud);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      stg_r[k] <= stg_nxt[k];
    end
  end

  // ---------------------------------------------------------------------------
  // result stage: underflow check, divisor, slot lookup, error masking
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [ubdc_pkg::DivW-1:0]     q;
    logic [ubdc_pkg::SlotIdxW-1:0] sidx;
    q    = stg_r[ubdc_pkg::Stages].acc[ubdc_pkg::RateW-1:ubdc_pkg::SlotIdxW];
    sidx = stg_r[ubdc_pkg::Stages].acc[ubdc_pkg::SlotIdxW-1:0];
    out_item_nxt = '0;
    if (stg_r[ubdc_pkg::Stages].status != ubdc_pkg::StOk) begin
      out_item_nxt.status = stg_r[ubdc_pkg::Stages].status;
    end else if (q == '0) begin
      // source clock below 16x baud
      out_item_nxt.status = ubdc_pkg::StUnderflow;
    end else begin
      out_item_nxt.status       = ubdc_pkg::StOk;
      out_item_nxt.divisor      = q - 1'b1;
      out_item_nxt.slot_code    = ubdc_pkg::SlotTable[sidx];
      out_item_nxt.line_control = stg_r[ubdc_pkg::Stages].lc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[ubdc_pkg::Stages];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // every result traces back to an item accepted the pipeline latency earlier
  a_strobe_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, ubdc_pkg::Latency))
    else $error("result strobe without an item accepted at the pipeline latency");

  // an error result carries no divisor, slot pattern or line control
  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != ubdc_pkg::StOk) |->
      (out_item.divisor == '0 && out_item.slot_code == '0 &&
       out_item.line_control == '0))
    else $error("error result with nonzero payload");

  // a good result has a legal parity code
  a_ok_line_control: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == ubdc_pkg::StOk) |->
      (out_item.line_control[5:3] == ubdc_pkg::PcodeNone ||
       out_item.line_control[5:3] == ubdc_pkg::PcodeOdd ||
       out_item.line_control[5:3] == ubdc_pkg::PcodeEven))
    else $error("good result with illegal parity code");

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the uart baud divisor calculator
// drives line setting requests through the command port, predicts every
// result in the bench and compares it field by field as it leaves the block
// ----------------------------------------------------------------------------
module tb;
  import ubdc_pkg::*;

  localparam int CycleLimit  = 200_000;
  localparam int SegItems    = 96;   // random items per clock rate setting
  localparam int Segments    = 12;
  localparam int PrintLimit  = 40;

  // argument codes the package leaves unnamed, all refused by the block
  localparam logic [ParW-1:0]  ParBad      = 2'd3;
  localparam logic [StopW-1:0] StopOneHalf = 2'd0;
  localparam logic [StopW-1:0] StopBad     = 2'd3;

  // fractional slot patterns, one per sixteenth of a baud step
  localparam logic [SlotW-1:0] SLOT_PATTERNS [16] = '{
    16'h0000, 16'h0080, 16'h0808, 16'h0888,
    16'h2222, 16'h4924, 16'h4a52, 16'h54aa,
    16'h5555, 16'hd555, 16'hd5d5, 16'hddd5,
    16'hdddd, 16'hdfdd, 16'hdfdf, 16'hffdf
  };

  // usual line rates, used to pick realistic requests
  localparam int unsigned COMMON_BAUDS [11] = '{
    300, 1200, 9600, 19200, 38400, 57600, 115200, 230400, 460800, 921600, 3000000
  };

  // one line of the directed stimulus: either a clock rate write or a request
  typedef struct {
    bit               wr_cfg;
    logic [RateW-1:0] rate;
    in_item_t         req;
    bit               typed;     // expected result written out by hand
    out_item_t        res;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_item;
  logic             out_strobe;
  out_item_t        out_item;
  logic             cfg_wr_en;
  logic [RateW-1:0] cfg_wr_data;

  logic [RateW-1:0] model_clock_rate = '0;   // bench copy of the clock rate register
  out_item_t        pending_results[$];     // predicted results, oldest first
  dir_row_t         dir_rows[$];
  int               sender_gap_pct = 0;
  int               error_count    = 0;
  int               results_seen   = 0;
  int               cycle_count    = 0;

  uart_baud_divisor_calc dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_strobe  (out_strobe),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: argument checks in order, then divisor, slot and line control
  // ---------------------------------------------------------------------------
  function automatic out_item_t calc_line_setting(input in_item_t req,
                                                  input logic [RateW-1:0] rate);
    out_item_t         res;
    longint unsigned   denom;
    longint unsigned   quo;
    longint unsigned   slot_idx;
    logic [2:0]        pcode;
    logic              two_stop;
    res = '0;
    res.status = StOk;
    if (req.baud_rate == '0) begin
      res.status = StBadBaud;
    end else if (req.data_bits < DataBitsMin || req.data_bits > DataBitsMax) begin
      res.status = StBadData;
    end else if (req.parity_mode != ParNone && req.parity_mode != ParOdd &&
                 req.parity_mode != ParEven) begin
      res.status = StBadPar;
    end else if (req.stop_bits != StopOne && req.stop_bits != StopTwo) begin
      res.status = StBadStop;
    end else begin
      // the denominator is sixteen times the baud rate
      denom = 64'(req.baud_rate) << 4;
      quo   = 64'(rate) / denom;
      if (quo == 0) begin
        // clock too slow for the line rate: flagged rather than wrapped
        res.status = StUnderflow;
      end else begin
        slot_idx = (64'(rate) % denom) / 64'(req.baud_rate);
        case (req.parity_mode)
          ParOdd:  pcode = PcodeOdd;
          ParEven: pcode = PcodeEven;
          default: pcode = PcodeNone;
        endcase
        two_stop         = (req.stop_bits == StopTwo);
        res.divisor      = DivW'(quo - 1);
        res.slot_code    = SLOT_PATTERNS[slot_idx[3:0]];
        res.line_control = {pcode, two_stop, 2'(req.data_bits - DataBitsMin)};
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random requests: mostly well formed with bauds in and past the reach of the clock,
  // the rest raw noise across every field
  // ---------------------------------------------------------------------------
  function automatic in_item_t make_request(input logic [RateW-1:0] rate);
    in_item_t          req;
    logic [RateW-1:0]  top_baud;
    req.baud_rate   = BaudW'($urandom);
    req.data_bits   = DataW'($urandom);
    req.parity_mode = ParW'($urandom);
    req.stop_bits   = StopW'($urandom);
    if ($urandom_range(99) < 85) begin
      req.data_bits   = DataBitsMin + DataW'($urandom_range(3));
      req.parity_mode = ParW'($urandom_range(2));
      req.stop_bits   = $urandom_range(1) ? StopTwo : StopOne;
      // largest baud that still leaves a nonzero quotient
      top_baud = rate >> 4;
      if (top_baud > 32'h00ff_ffff)
        top_baud = 32'h00ff_ffff;
      case ($urandom_range(4))
        0: ;                                   // full width baud, usually underflow
        1: req.baud_rate = BaudW'($urandom_range(1000, 1));
        2: req.baud_rate = (top_baud == 0) ? BaudW'(1) :
                           BaudW'($urandom_range(top_baud, 1));
        3: req.baud_rate = BaudW'(top_baud + $urandom_range(1));  // quotient edge
        default: req.baud_rate = BaudW'(COMMON_BAUDS[$urandom_range(10)]);
      endcase
      if (req.baud_rate == '0)
        req.baud_rate = BaudW'(1);
    end else if ($urandom_range(9) == 0) begin
      req.baud_rate = '0;
    end
    return req;
  endfunction

  function automatic logic [RateW-1:0] pick_clock_rate(input int seg);
    logic [RateW-1:0] rate;
    case (seg % 6)
      0: rate = 32'hffff_ffff;
      1: rate = '0;
      2: rate = RateW'($urandom_range(20000));
      3: rate = $urandom;
      default: begin
        case ($urandom_range(4))
          0: rate = 32'd1_843_200;
          1: rate = 32'd7_372_800;
          2: rate = 32'd24_000_000;
          3: rate = 32'd48_000_000;
          default: rate = 32'd100_000_000;
        endcase
      end
    endcase
    return rate;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------
  function automatic dir_row_t cfg_row(input logic [RateW-1:0] rate);
    dir_row_t row;
    row        = '{default: '0};
    row.wr_cfg = 1'b1;
    row.rate   = rate;
    return row;
  endfunction

  function automatic dir_row_t req_row(input int unsigned baud, input int unsigned dbits,
                                       input logic [ParW-1:0] par,
                                       input logic [StopW-1:0] stop, input bit typed,
                                       input status_t st, input logic [DivW-1:0] div,
                                       input logic [SlotW-1:0] slot,
                                       input logic [LcW-1:0] lc);
    dir_row_t row;
    row                     = '{default: '0};
    row.req.baud_rate       = BaudW'(baud);
    row.req.data_bits       = DataW'(dbits);
    row.req.parity_mode     = par;
    row.req.stop_bits       = stop;
    row.typed               = typed;
    row.res.status          = st;
    row.res.divisor         = div;
    row.res.slot_code       = slot;
    row.res.line_control    = lc;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers: all inputs move on the falling edge, tasks start and end there
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (error_count < PrintLimit)
      $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
    error_count++;
  endtask

  task automatic send_item(input in_item_t req, input bit typed, input out_item_t typed_res);
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    // busy is read just after the edge, so it is the value that decided it
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.push_back(typed ? typed_res : calc_line_setting(req, model_clock_rate));
    @(negedge clk);
  endtask

  // stop sending until every predicted result has left the block
  task automatic wait_for_drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // register writes only with the pipeline empty
  task automatic write_clock_rate(input logic [RateW-1:0] rate);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(negedge clk);
    cfg_wr_en        <= 1'b0;
    model_clock_rate  = rate;
  endtask

  // ---------------------------------------------------------------------------
  // result checker: one result per strobe, compared with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_item));
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", out_item.status, want.status));
        if (out_item.divisor !== want.divisor)
          report_mismatch($sformatf("divisor %h, wanted %h", out_item.divisor, want.divisor));
        if (out_item.slot_code !== want.slot_code)
          report_mismatch($sformatf("slot code %h, wanted %h",
                                    out_item.slot_code, want.slot_code));
        if (out_item.line_control !== want.line_control)
          report_mismatch($sformatf("line control %h, wanted %h",
                                    out_item.line_control, want.line_control));
      end
      results_seen++;
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;

    // clock rate is zero out of reset: any valid request underflows
    dir_rows.push_back(req_row(0, 8, ParNone, StopOne, 1, StBadBaud, 0, 0, 0));
    dir_rows.push_back(req_row(9600, 5, ParNone, StopOne, 1, StUnderflow, 0, 0, 0));
    // classic crystal: exact division, divisor zero
    dir_rows.push_back(cfg_row(32'd1_843_200));
    dir_rows.push_back(req_row(115200, 8, ParNone, StopOne, 1, StOk, 0, 0, 6'h03));
    dir_rows.push_back(req_row(24'hff_ffff, 8, ParNone, StopOne, 1, StUnderflow, 0, 0, 0));
    // data bit count out of range on both sides
    dir_rows.push_back(req_row(9600, 4, ParNone, StopOne, 1, StBadData, 0, 0, 0));
    dir_rows.push_back(req_row(9600, 9, ParNone, StopOne, 1, StBadData, 0, 0, 0));
    dir_rows.push_back(req_row(9600, 15, ParNone, StopOne, 1, StBadData, 0, 0, 0));
    dir_rows.push_back(req_row(9600, 0, ParNone, StopOne, 1, StBadData, 0, 0, 0));
    dir_rows.push_back(req_row(9600, 5, ParBad, StopOne, 1, StBadPar, 0, 0, 0));
    // one and a half stop bits is refused, as is the unused code
    dir_rows.push_back(req_row(9600, 5, ParOdd, StopOneHalf, 1, StBadStop, 0, 0, 0));
    dir_rows.push_back(req_row(9600, 5, ParOdd, StopBad, 1, StBadStop, 0, 0, 0));
    // several bad arguments at once: the first in check order wins
    dir_rows.push_back(req_row(0, 0, ParBad, StopOneHalf, 1, StBadBaud, 0, 0, 0));
    dir_rows.push_back(req_row(9600, 0, ParBad, StopOneHalf, 1, StBadData, 0, 0, 0));
    dir_rows.push_back(req_row(9600, 8, ParBad, StopOneHalf, 1, StBadPar, 0, 0, 0));
    dir_rows.push_back(req_row(9600, 5, ParOdd, StopTwo, 0, StOk, 0, 0, 0));
    dir_rows.push_back(req_row(9600, 6, ParEven, StopOne, 0, StOk, 0, 0, 0));
    dir_rows.push_back(req_row(38400, 7, ParNone, StopTwo, 0, StOk, 0, 0, 0));
    // full scale clock: largest divisor, last slot pattern
    dir_rows.push_back(cfg_row(32'hffff_ffff));
    dir_rows.push_back(req_row(1, 8, ParEven, StopTwo, 1, StOk, 28'hfff_fffe, 16'hffdf, 6'h2f));
    dir_rows.push_back(req_row(24'hff_ffff, 5, ParOdd, StopOne, 0, StOk, 0, 0, 0));
    dir_rows.push_back(req_row(3, 8, ParOdd, StopTwo, 0, StOk, 0, 0, 0));
    // clock one short of sixteen times the baud
    dir_rows.push_back(cfg_row(32'd153_599));
    dir_rows.push_back(req_row(9600, 8, ParNone, StopOne, 1, StUnderflow, 0, 0, 0));
    dir_rows.push_back(req_row(9599, 8, ParNone, StopOne, 0, StOk, 0, 0, 0));
    dir_rows.push_back(cfg_row(32'd48_000_000));
    dir_rows.push_back(req_row(115200, 8, ParEven, StopOne, 0, StOk, 0, 0, 0));
    dir_rows.push_back(req_row(3000000, 5, ParNone, StopTwo, 0, StOk, 0, 0, 0));
    dir_rows.push_back(req_row(777, 6, ParOdd, StopOne, 0, StOk, 0, 0, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, light sender gaps
    sender_gap_pct = 14;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_cfg)
        write_clock_rate(dir_rows[i].rate);
      else
        send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    end

    // random part: sender gaps light, then heavy, then none at all,
    // with a fresh clock rate for every segment
    for (int seg = 0; seg < Segments; seg++) begin
      sender_gap_pct = (seg < 4) ? 14 : ((seg < 8) ? 63 : 0);
      write_clock_rate(pick_clock_rate(seg));
      repeat (SegItems) begin
        if ($urandom_range(79) == 0)
          wait_for_drain();
        send_item(make_request(model_clock_rate), 1'b0, '0);
      end
    end

    wait_for_drain();
    // a little longer in case a stray result follows
    repeat (Latency + 4) @(posedge clk);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: uart_baud_divisor_calc.f
hw/rtl/ubdc_pkg.sv
hw/rtl/uart_baud_divisor_calc.sv
tb/tb.sv
